/* rtl/core/vwqt_pkg.sv */
// ----------------------------------------------------------------------------
// vwqt_pkg
// shared types and constants for the vertex weld quad triangulator
// ----------------------------------------------------------------------------
package vwqt_pkg;

  localparam int POINT_DEPTH = 4096;
  localparam int IDX_W       = $clog2(POINT_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam logic OP_CORNER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic KIND_CORNER = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  // triangle candidates of the quad that just completed
  typedef struct packed {
    logic             a_ok;
    logic             b_ok;
    logic [IDX_W-1:0] c0;
    logic [IDX_W-1:0] c1;
    logic [IDX_W-1:0] c2;
    logic [IDX_W-1:0] c3;
  } quad_tri_t;

  function automatic logic all_differ(input logic [IDX_W-1:0] a,
                                      input logic [IDX_W-1:0] b,
                                      input logic [IDX_W-1:0] c);
    return (a != b) && (a != c) && (b != c);
  endfunction

endpackage

/* rtl/core/vertex_weld_quad_triangulator.sv */
// ----------------------------------------------------------------------------
// vertex_weld_quad_triangulator
// welds quad corners into a point store and emits the quad's triangles
// ----------------------------------------------------------------------------
// usage:
//   raise start with op and x_bits/y_bits/z_bits while busy is low; the beat
//   is taken at that edge. op = clear empties the store and corner counter
//   and gives no result.
//   a corner is compared against the stored points one per cycle through the
//   single read port of the point memory.
//   results appear on kind/point_index/is_new/tri_*/store_full/last for one
//   cycle each, marked by strobe, back to back: the corner report, then up to
//   two triangles after the fourth corner of a quad. last marks the final one.
//   busy stays high until the last result is registered: the search ends on a
//   hit or after the last stored entry (at once when the store is empty), and
//   each triangle adds one more state before busy drops.
//   the receiver cannot stall; results are never held back.
//   reset empties the store and quad state; no memory clearing pass is needed
//   since only entries below the point count are ever compared.
// ----------------------------------------------------------------------------
module vertex_weld_quad_triangulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] x_bits,
  input  logic [31:0] y_bits,
  input  logic [31:0] z_bits,
  output logic        strobe,
  output logic        kind,
  output logic [12:0] point_index,
  output logic        is_new,
  output logic [11:0] tri_first,
  output logic [11:0] tri_second,
  output logic [11:0] tri_third,
  output logic        store_full,
  output logic        last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_TRI_A = 2'd2;
  localparam logic [1:0] ST_TRI_B = 2'd3;

  logic [1:0]                 state;
  logic [1:0]                 state_next;
  logic [vwqt_pkg::CNT_W-1:0] point_count;
  logic [vwqt_pkg::IDX_W-1:0] scan_idx;
  logic [vwqt_pkg::IDX_W-1:0] cmp_idx;
  logic                       cmp_valid;
  logic                       tri_b_pend;
  vwqt_pkg::point_t           key;
  vwqt_pkg::point_t           rd_data;
  vwqt_pkg::quad_tri_t        quad_tri;

  logic                       accept;
  logic                       clear;
  logic                       hit;
  logic                       miss;
  logic                       resolve;
  logic                       has_room;
  logic                       store_we;
  logic [vwqt_pkg::CNT_W-1:0] res_idx;
  logic                       res_full;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign clear  = accept && (op == vwqt_pkg::OP_CLEAR);

  // compare works on the read address of the cycle before
  assign hit  = (state == ST_SCAN) && cmp_valid && (rd_data == key);
  assign miss = (state == ST_SCAN) && !hit &&
                ((point_count == '0) ||
                 (cmp_valid && ({1'b0, cmp_idx} == point_count - 1'b1)));
  assign resolve  = hit || miss;
  assign has_room = (point_count < vwqt_pkg::CNT_W'(vwqt_pkg::POINT_DEPTH));
  assign store_we = miss && has_room;
  assign res_full = miss && !has_room;

  always_comb begin
    if (hit) begin
      res_idx = {1'b0, cmp_idx};
    end else if (has_room) begin
      res_idx = point_count;
    end else begin
      res_idx = vwqt_pkg::CNT_W'(vwqt_pkg::POINT_DEPTH);
    end
  end

  vwqt_point_mem u_mem (
    .clk   (clk),
    .we    (store_we),
    .waddr (point_count[vwqt_pkg::IDX_W-1:0]),
    .wdata (key),
    .raddr (scan_idx),
    .rdata (rd_data)
  );

  vwqt_quad u_quad (
    .clk    (clk),
    .rst    (rst),
    .clear  (clear),
    .corner (resolve),
    .idx    (res_idx),
    .full   (res_full),
    .tri_o  (quad_tri)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && op == vwqt_pkg::OP_CORNER) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (resolve) begin
          if (quad_tri.a_ok) begin
            state_next = ST_TRI_A;
          end else if (quad_tri.b_ok) begin
            state_next = ST_TRI_B;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_TRI_A: state_next = tri_b_pend ? ST_TRI_B : ST_IDLE;
      ST_TRI_B: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      cmp_valid   <= 1'b0;
      tri_b_pend  <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= resolve || (state == ST_TRI_A) || (state == ST_TRI_B);
      if (clear) begin
        point_count <= '0;
      end else if (store_we) begin
        point_count <= point_count + 1'b1;
      end
      if (accept) begin
        cmp_valid <= 1'b0;
      end else if (state == ST_SCAN) begin
        cmp_valid <= 1'b1;
      end
      if (resolve) begin
        tri_b_pend <= quad_tri.b_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= '{x: x_bits, y: y_bits, z: z_bits};
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      cmp_idx  <= scan_idx;
    end
  end

  // result beat registers
  always_ff @(posedge clk) begin
    if (resolve) begin
      kind        <= vwqt_pkg::KIND_CORNER;
      point_index <= res_idx;
      is_new      <= store_we;
      store_full  <= res_full;
      tri_first   <= '0;
      tri_second  <= '0;
      tri_third   <= '0;
      last        <= !(quad_tri.a_ok || quad_tri.b_ok);
    end else if (state == ST_TRI_A) begin
      kind        <= vwqt_pkg::KIND_TRI;
      point_index <= '0;
      is_new      <= 1'b0;
      store_full  <= 1'b0;
      tri_first   <= quad_tri.c0;
      tri_second  <= quad_tri.c1;
      tri_third   <= quad_tri.c2;
      last        <= !tri_b_pend;
    end else if (state == ST_TRI_B) begin
      kind        <= vwqt_pkg::KIND_TRI;
      point_index <= '0;
      is_new      <= 1'b0;
      store_full  <= 1'b0;
      tri_first   <= quad_tri.c2;
      tri_second  <= quad_tri.c3;
      tri_third   <= quad_tri.c0;
      last        <= 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= vwqt_pkg::CNT_W'(vwqt_pkg::POINT_DEPTH))
    else $error("point count beyond store depth");

  a_tri_distinct: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == vwqt_pkg::KIND_TRI |->
      tri_first != tri_second && tri_first != tri_third && tri_second != tri_third)
    else $error("triangle with repeated index");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a result burst");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    strobe && store_full |-> point_index == 13'(vwqt_pkg::POINT_DEPTH) && !is_new)
    else $error("full corner reported with a store index");

  a_corner_busy: assert property (@(posedge clk) disable iff (rst)
    accept && op == vwqt_pkg::OP_CORNER |=> busy)
    else $error("corner taken without going busy");

endmodule

/* rtl/core/vwqt_point_mem.sv */
// ----------------------------------------------------------------------------
// vwqt_point_mem
// point store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module vwqt_point_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [vwqt_pkg::IDX_W-1:0] waddr,
  input  vwqt_pkg::point_t          wdata,
  input  logic [vwqt_pkg::IDX_W-1:0] raddr,
  output vwqt_pkg::point_t          rdata
);

  vwqt_pkg::point_t mem [vwqt_pkg::POINT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/vwqt_quad.sv */
// ----------------------------------------------------------------------------
// vwqt_quad
// corner counter, corner indices and overflow mark of the current quad
// ----------------------------------------------------------------------------
module vwqt_quad (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       corner,
  input  logic [vwqt_pkg::CNT_W-1:0] idx,
  input  logic                       full,
  output vwqt_pkg::quad_tri_t        tri_o
);

  logic [1:0]                 corner_counter;
  logic                       overflowed;
  logic [vwqt_pkg::IDX_W-1:0] c0;
  logic [vwqt_pkg::IDX_W-1:0] c1;
  logic [vwqt_pkg::IDX_W-1:0] c2;
  logic [vwqt_pkg::IDX_W-1:0] c3;
  logic                       overflow_now;
  logic                       fourth;
  logic [vwqt_pkg::IDX_W-1:0] idx_low;

  assign overflow_now = overflowed | full;
  assign fourth       = (corner_counter == 2'd3);
  assign idx_low      = idx[vwqt_pkg::IDX_W-1:0];

  // decided in the cycle the fourth corner resolves
  assign tri_o.a_ok = corner && fourth && !overflow_now &&
                      vwqt_pkg::all_differ(c0, c1, c2);
  assign tri_o.b_ok = corner && fourth && !overflow_now &&
                      vwqt_pkg::all_differ(c2, idx_low, c0);
  assign tri_o.c0   = c0;
  assign tri_o.c1   = c1;
  assign tri_o.c2   = c2;
  assign tri_o.c3   = c3;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      corner_counter <= 2'd0;
      overflowed     <= 1'b0;
      c0             <= '0;
      c1             <= '0;
      c2             <= '0;
      c3             <= '0;
    end else if (corner) begin
      case (corner_counter)
        2'd0:    c0 <= idx_low;
        2'd1:    c1 <= idx_low;
        2'd2:    c2 <= idx_low;
        default: c3 <= idx_low;
      endcase
      if (fourth) begin
        corner_counter <= 2'd0;
        overflowed     <= 1'b0;
      end else begin
        corner_counter <= corner_counter + 2'd1;
        overflowed     <= overflow_now;
      end
    end
  end

endmodule

/* tb/vertex_weld_quad_triangulator_check.sv */
// ----------------------------------------------------------------------------
// vertex_weld_quad_triangulator_check
// watches the command and result channels, predicts every result beat from
// a private weld table and quad tracker, and compares them field by field
// ----------------------------------------------------------------------------
module vertex_weld_quad_triangulator_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        op,
  input  logic [31:0] x_bits,
  input  logic [31:0] y_bits,
  input  logic [31:0] z_bits,
  input  logic        strobe,
  input  logic        kind,
  input  logic [12:0] point_index,
  input  logic        is_new,
  input  logic [11:0] tri_first,
  input  logic [11:0] tri_second,
  input  logic [11:0] tri_third,
  input  logic        store_full,
  input  logic        last,
  output int          mismatches,
  output int          awaited,
  output int          results_checked
);

  typedef struct packed {
    logic                       kind;
    logic [vwqt_pkg::CNT_W-1:0] point_index;
    logic                       is_new;
    logic [vwqt_pkg::IDX_W-1:0] tri_first;
    logic [vwqt_pkg::IDX_W-1:0] tri_second;
    logic [vwqt_pkg::IDX_W-1:0] tri_third;
    logic                       store_full;
    logic                       last;
  } weld_result_t;

  weld_result_t               awaited_results[$];
  // welded points keyed by their full 96-bit pattern
  int unsigned                point_slot[bit [95:0]];
  int unsigned                stored_points;
  logic [1:0]                 corner_slot;
  logic [vwqt_pkg::CNT_W-1:0] quad_corners[4];
  logic                       quad_lost;

  function automatic logic distinct3(input logic [vwqt_pkg::CNT_W-1:0] a, b, c);
    return (a != b) && (a != c) && (b != c);
  endfunction

  task automatic clear_model();
    point_slot.delete();
    stored_points = 0;
    corner_slot   = '0;
    quad_lost     = 1'b0;
    for (int i = 0; i < 4; i++) quad_corners[i] = '0;
  endtask

  task automatic push_triangle(input logic [vwqt_pkg::CNT_W-1:0] a, b, c,
                               input logic is_last);
    weld_result_t tri_beat;
    tri_beat            = '0;
    tri_beat.kind       = vwqt_pkg::KIND_TRI;
    tri_beat.tri_first  = a[vwqt_pkg::IDX_W-1:0];
    tri_beat.tri_second = b[vwqt_pkg::IDX_W-1:0];
    tri_beat.tri_third  = c[vwqt_pkg::IDX_W-1:0];
    tri_beat.last       = is_last;
    awaited_results.push_back(tri_beat);
  endtask

  task automatic weld_corner(input bit [95:0] pt);
    weld_result_t               report;
    logic [vwqt_pkg::CNT_W-1:0] idx;
    logic                       fresh, full, closing, keep_a, keep_b;
    fresh = 1'b0;
    full  = 1'b0;
    if (point_slot.exists(pt)) begin
      idx = vwqt_pkg::CNT_W'(point_slot[pt]);
    end else if (stored_points < vwqt_pkg::POINT_DEPTH) begin
      idx = vwqt_pkg::CNT_W'(stored_points);
      point_slot[pt] = stored_points;
      stored_points++;
      fresh = 1'b1;
    end else begin
      idx       = vwqt_pkg::CNT_W'(vwqt_pkg::POINT_DEPTH);
      full      = 1'b1;
      quad_lost = 1'b1;
    end
    quad_corners[corner_slot] = idx;
    closing = (corner_slot == 2'd3);
    keep_a  = closing && !quad_lost &&
              distinct3(quad_corners[0], quad_corners[1], quad_corners[2]);
    keep_b  = closing && !quad_lost &&
              distinct3(quad_corners[2], quad_corners[3], quad_corners[0]);

    report             = '0;
    report.kind        = vwqt_pkg::KIND_CORNER;
    report.point_index = idx;
    report.is_new      = fresh;
    report.store_full  = full;
    report.last        = !(keep_a || keep_b);
    awaited_results.push_back(report);
    if (keep_a) push_triangle(quad_corners[0], quad_corners[1], quad_corners[2], !keep_b);
    if (keep_b) push_triangle(quad_corners[2], quad_corners[3], quad_corners[0], 1'b1);

    if (closing) begin
      corner_slot = '0;
      quad_lost   = 1'b0;
    end else begin
      corner_slot = corner_slot + 2'd1;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    weld_result_t want;
    if (awaited_results.size() == 0) begin
      $error("result beat with nothing outstanding (kind %0d index %0d)", kind, point_index);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      results_checked++;
      compare_field("kind", 32'(want.kind), 32'(kind));
      compare_field("point_index", 32'(want.point_index), 32'(point_index));
      compare_field("is_new", 32'(want.is_new), 32'(is_new));
      compare_field("tri_first", 32'(want.tri_first), 32'(tri_first));
      compare_field("tri_second", 32'(want.tri_second), 32'(tri_second));
      compare_field("tri_third", 32'(want.tri_third), 32'(tri_third));
      compare_field("store_full", 32'(want.store_full), 32'(store_full));
      compare_field("last", 32'(want.last), 32'(last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      awaited_results.delete();
      mismatches      = 0;
      results_checked = 0;
    end else begin
      if (strobe) check_result();
      if (start && !busy) begin
        if (op == vwqt_pkg::OP_CLEAR) clear_model();
        else weld_corner({x_bits, y_bits, z_bits});
      end
    end
    awaited = awaited_results.size();
  end

endmodule

/* tb/vertex_weld_quad_triangulator_test.sv */
// ----------------------------------------------------------------------------
// vertex_weld_quad_triangulator_test
// drives corner and clear commands into the triangulator: directed corners
// with signed zeros, nan patterns and collapsed quads, then a random quad
// stream with reused points, near misses and clears
// ----------------------------------------------------------------------------
module vertex_weld_quad_triangulator_test;

  logic        clk    = 1'b0;
  logic        rst    = 1'b1;
  logic        start  = 1'b0;
  logic        op     = vwqt_pkg::OP_CORNER;
  logic [31:0] x_bits = '0;
  logic [31:0] y_bits = '0;
  logic [31:0] z_bits = '0;
  logic        busy, strobe, kind, is_new, store_full, last;
  logic [12:0] point_index;
  logic [11:0] tri_first, tri_second, tri_third;

  int          mismatches, awaited, results_checked;
  int          idle_pct = 36;
  int          items_sent, clears_sent;
  bit [95:0]   sent_points[$];

  vertex_weld_quad_triangulator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .x_bits(x_bits), .y_bits(y_bits), .z_bits(z_bits),
    .strobe(strobe), .kind(kind), .point_index(point_index), .is_new(is_new),
    .tri_first(tri_first), .tri_second(tri_second), .tri_third(tri_third),
    .store_full(store_full), .last(last)
  );

  vertex_weld_quad_triangulator_check checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .x_bits(x_bits), .y_bits(y_bits), .z_bits(z_bits),
    .strobe(strobe), .kind(kind), .point_index(point_index), .is_new(is_new),
    .tri_first(tri_first), .tri_second(tri_second), .tri_third(tri_third),
    .store_full(store_full), .last(last),
    .mismatches(mismatches), .awaited(awaited), .results_checked(results_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("vertex_weld_quad_triangulator: mismatch");
    $finish;
  end

  task automatic rest(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input logic beat_op, input bit [95:0] pt);
    start <= 1'b1;
    op    <= beat_op;
    {x_bits, y_bits, z_bits} <= pt;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (beat_op == vwqt_pkg::OP_CLEAR) begin
      sent_points.delete();
      clears_sent++;
    end else begin
      sent_points.push_back(pt);
    end
    if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
      rest(($urandom_range(9, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  function automatic bit [31:0] odd_word();
    case ($urandom_range(4, 0))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FC0_0000;
      default: return 32'h7F80_0000;
    endcase
  endfunction

  function automatic bit [95:0] pick_corner();
    bit [95:0] pt;
    int        roll, depth;
    roll = $urandom_range(99, 0);
    if (sent_points.size() != 0 && roll < 25) begin
      // a recent corner, so quads fold and lose triangles
      depth = (sent_points.size() < 3) ? sent_points.size() : 3;
      pt = sent_points[sent_points.size() - 1 - $urandom_range(depth - 1, 0)];
    end else if (sent_points.size() != 0 && roll < 45) begin
      pt = sent_points[$urandom_range(sent_points.size() - 1, 0)];
    end else if (sent_points.size() != 0 && roll < 52) begin
      // near miss: one bit away from a stored point
      pt = sent_points[$urandom_range(sent_points.size() - 1, 0)];
      pt[$urandom_range(95, 0)] ^= 1'b1;
    end else if (roll < 62) begin
      pt = {odd_word(), odd_word(), odd_word()};
    end else begin
      pt = {$urandom, $urandom, $urandom};
    end
    return pt;
  endfunction

  initial begin
    bit [95:0] nan_pt, inf_pt;
    int        leftover;
    nan_pt = {32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000};
    inf_pt = {32'h7F80_0000, 32'hFF80_0000, 32'h0000_0001};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: clear ignores its coordinates
    send_beat(vwqt_pkg::OP_CLEAR, {$urandom, $urandom, $urandom});
    // +0, all ones, -0 in x, +0 again: second triangle folds
    send_beat(vwqt_pkg::OP_CORNER, 96'h0);
    send_beat(vwqt_pkg::OP_CORNER, {96{1'b1}});
    send_beat(vwqt_pkg::OP_CORNER, {32'h8000_0000, 32'h0, 32'h0});
    send_beat(vwqt_pkg::OP_CORNER, 96'h0);
    // identical nan patterns weld; first triangle folds
    send_beat(vwqt_pkg::OP_CORNER, nan_pt);
    send_beat(vwqt_pkg::OP_CORNER, nan_pt);
    send_beat(vwqt_pkg::OP_CORNER, {32'h0, 32'h8000_0000, 32'h0});
    send_beat(vwqt_pkg::OP_CORNER, {32'h0, 32'h0, 32'h8000_0000});
    // whole quad on one point
    repeat (4) send_beat(vwqt_pkg::OP_CORNER, inf_pt);
    // four fresh corners
    repeat (4) send_beat(vwqt_pkg::OP_CORNER, {$urandom, $urandom, $urandom});
    // clear in the middle of a quad
    repeat (2) send_beat(vwqt_pkg::OP_CORNER, {$urandom, $urandom, $urandom});
    send_beat(vwqt_pkg::OP_CLEAR, {$urandom, $urandom, $urandom});
    send_beat(vwqt_pkg::OP_CORNER, 96'h0);
    send_beat(vwqt_pkg::OP_CORNER, {96{1'b1}});
    send_beat(vwqt_pkg::OP_CORNER, {32'h8000_0000, 32'h0, 32'h0});
    send_beat(vwqt_pkg::OP_CORNER, nan_pt);
    drain();

    // random quad stream
    for (int n = 0; n < 116; n++) begin
      idle_pct = (n >= 40 && n < 80) ? 0 : 36;
      if ($urandom_range(99, 0) < 4) begin
        send_beat(vwqt_pkg::OP_CLEAR, {$urandom, $urandom, $urandom});
      end else begin
        send_beat(vwqt_pkg::OP_CORNER, pick_corner());
      end
      if ($urandom_range(29, 0) == 0) drain();
    end

    start <= 1'b0;
    for (int w = 0; w < 20000 && awaited != 0; w++) @(negedge clk);
    leftover = awaited;
    if (leftover != 0) $error("%0d expected result beats never arrived", leftover);
    repeat (20) @(negedge clk);

    $display("checked %0d result beats from %0d commands, %0d of them clears",
             results_checked, items_sent, clears_sent);
    $display("corners included signed zeros, nan patterns, near misses and folded quads");
    if (mismatches == 0 && leftover == 0) begin
      $display("vertex_weld_quad_triangulator: match");
    end else begin
      $display("vertex_weld_quad_triangulator: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/vwqt_pkg.sv
rtl/core/vwqt_point_mem.sv
rtl/core/vwqt_quad.sv
rtl/core/vertex_weld_quad_triangulator.sv
tb/vertex_weld_quad_triangulator_check.sv
tb/vertex_weld_quad_triangulator_test.sv
